FILE: sv/cafilt_pkg.sv
// Shared types, codes and the acceptance compare for the CAN filter table.
`timescale 1ns / 1ps

package cafilt_pkg;

  // Default table capacity
  localparam int unsigned MAX_ENTRIES_DEF = 128;

  // Field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned BUS_W    = 16;
  localparam int unsigned ID_W     = 29;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned S_DATA_W = 128;
  localparam int unsigned M_DATA_W = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd2;

  // Bus filter value that accepts every bus
  localparam logic [BUS_W-1:0] BUS_ANY = 16'hFFFF;

  // One stored filter
  typedef struct packed {
    logic [BUS_W-1:0]  bus;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] code;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Mask bit one means don't care; bus must match or the filter is a wildcard
  function automatic logic entry_accepts(entry_t e, logic [ID_W-1:0] id,
                                         logic [BUS_W-1:0] bus);
    logic [CODE_W-1:0] care;
    logic              id_ok;
    logic              bus_ok;
    care   = ~e.mask;
    id_ok  = ((CODE_W'(id) & care) == (e.code & care));
    bus_ok = (e.bus == bus) || (e.bus == BUS_ANY);
    return id_ok && bus_ok;
  endfunction

endpackage

FILE: sv/cafilt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cafilt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/can_acceptance_filter_table_core.sv
// Top level: CAN acceptance filter table with one shared entry comparator.
// Sequence: add, clear and unknown kinds pass through the done state to the output register;
//   a match first walks the filters in the scan state up to the first hit or the fill count.
// Throughput: one word in flight; the next is taken in the cycle after the result loads, and the
//   compare unit walks one entry per cycle through the registered RAM read port.
// Reset: asynchronous, active low; clears the filter count and control state, not the table.
`timescale 1ns / 1ps

module can_acceptance_filter_table_core #(
  parameter int unsigned MAX_ENTRIES = cafilt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: acceptance_code[31:0], acceptance_mask[63:32],
  // bus_filter[79:64], message_id[108:80], message_bus[124:109], zero pad
  input  logic [cafilt_pkg::S_DATA_W-1:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [cafilt_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: matched[0], add_dropped[1], filter_count[9:2], zero pad
  output logic [cafilt_pkg::M_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EXT_W = (CNT_W > 8) ? CNT_W : 8;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic [CNT_W-1:0]                 issue_q, issue_d;
  logic                             rd_pend_q, rd_pend_d;
  logic                             res_match_q, res_match_d;
  logic                             res_drop_q, res_drop_d;
  logic [cafilt_pkg::ID_W-1:0]      id_q;
  logic [cafilt_pkg::BUS_W-1:0]     mbus_q;
  logic                             m_valid_q, m_valid_d;
  logic [cafilt_pkg::M_DATA_W-1:0]  m_data_q, m_data_d;

  // Unpack the input word
  logic [cafilt_pkg::KIND_W-1:0]    in_kind;
  cafilt_pkg::entry_t               in_entry;
  logic [cafilt_pkg::ID_W-1:0]      in_id;
  logic [cafilt_pkg::BUS_W-1:0]     in_bus;

  assign in_kind        = s_axis_tuser;
  assign in_entry.code  = s_axis_tdata[31:0];
  assign in_entry.mask  = s_axis_tdata[63:32];
  assign in_entry.bus   = s_axis_tdata[79:64];
  assign in_id          = s_axis_tdata[108:80];
  assign in_bus         = s_axis_tdata[124:109];

  logic in_acc;
  logic full;
  logic wr_en;
  logic rd_en;
  logic hit_now;
  logic out_free;
  cafilt_pkg::entry_t rd_entry;
  logic [EXT_W-1:0]   cnt_ext;
  logic [cafilt_pkg::COUNT_W-1:0] count_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(MAX_ENTRIES));
  // Append at the fill count in the accept cycle
  assign wr_en         = in_acc && (in_kind == cafilt_pkg::KIND_ADD) && !full;

  // Shared comparator against the entry read last cycle
  assign hit_now  = rd_pend_q && cafilt_pkg::entry_accepts(rd_entry, id_q, mbus_q);
  assign rd_en    = (state_q == ST_SCAN) && (issue_q < count_q) && !hit_now;
  assign out_free = !m_valid_q || m_axis_tready;

  // Saturate the reported count at 255 for large tables
  assign cnt_ext   = EXT_W'(count_q);
  assign count_sat = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];

  cafilt_ram #(
    .WIDTH (cafilt_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_entry),
    .re_i    (rd_en),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    rd_pend_d   = rd_pend_q;
    res_match_d = res_match_q;
    res_drop_d  = res_drop_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;

    // Drop the output word once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_match_d = 1'b0;
          res_drop_d  = 1'b0;
          issue_d     = '0;
          rd_pend_d   = 1'b0;
          priority if (in_kind == cafilt_pkg::KIND_ADD) begin
            if (full) begin
              res_drop_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
            end
            state_d = ST_DONE;
          end else if (in_kind == cafilt_pkg::KIND_CLEAR) begin
            count_d = '0;
            state_d = ST_DONE;
          end else if (in_kind == cafilt_pkg::KIND_MATCH) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // Advance one entry per cycle, stop at the first hit or the fill count
        rd_pend_d = rd_en;
        if (rd_en) begin
          issue_d = issue_q + CNT_W'(1);
        end
        if (hit_now) begin
          res_match_d = 1'b1;
          state_d     = ST_DONE;
        end else if ((issue_q >= count_q) && !rd_pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, count_sat, res_drop_q, res_match_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      rd_pend_q <= rd_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_match_q <= res_match_d;
    res_drop_q  <= res_drop_d;
    m_data_q    <= m_data_d;
    if (in_acc) begin
      id_q   <= in_id;
      mbus_q <= in_bus;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: sv/cafilt_checker.sv
// Port-level checks for the CAN filter table, bound to the top level.
`timescale 1ns / 1ps

module cafilt_checker #(
  parameter int unsigned MAX_ENTRIES = cafilt_pkg::MAX_ENTRIES_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cafilt_pkg::M_DATA_W-1:0] m_axis_tdata
);

  localparam logic [7:0] FULL_CNT = (MAX_ENTRIES > 255) ? 8'hFF : 8'(MAX_ENTRIES);

  // A word never reports both a hit and a refused add
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("matched and add_dropped both set");

  // A refused add only happens on a full table
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[9:2] == FULL_CNT))
    else $error("add dropped while table not full");

  // A hit needs at least one stored filter
  a_hit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[9:2] != 8'd0))
    else $error("match reported on empty table");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

endmodule

bind can_acceptance_filter_table_core cafilt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_cafilt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/can_filter_table_checker.sv
// Checker for the CAN filter table: mirrors the table, queues verdicts, compares results.
`timescale 1ns / 1ps

module can_filter_table_checker #(
  parameter int unsigned MAX_ENTRIES = cafilt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [cafilt_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic [cafilt_pkg::KIND_W-1:0]   s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [cafilt_pkg::M_DATA_W-1:0] m_tdata_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              results_o,
  output int                              hits_o,
  output int                              drops_o
);

  typedef struct packed {
    logic [cafilt_pkg::COUNT_W-1:0] count;
    logic                           dropped;
    logic                           hit;
  } verdict_t;

  logic [cafilt_pkg::CODE_W-1:0] code_tbl [MAX_ENTRIES];
  logic [cafilt_pkg::CODE_W-1:0] mask_tbl [MAX_ENTRIES];
  logic [cafilt_pkg::BUS_W-1:0]  bus_tbl  [MAX_ENTRIES];
  int                            held;
  verdict_t                      verdict_q [$];
  int                            err_cnt  = 0;
  int                            res_cnt  = 0;
  int                            hit_cnt  = 0;
  int                            drop_cnt = 0;

  // Apply one word to the mirrored table and return the verdict it should give
  function automatic verdict_t table_step(input logic [cafilt_pkg::KIND_W-1:0] kind,
                                          input logic [cafilt_pkg::S_DATA_W-1:0] data);
    verdict_t                      v;
    logic [cafilt_pkg::CODE_W-1:0] code;
    logic [cafilt_pkg::CODE_W-1:0] mask;
    logic [cafilt_pkg::CODE_W-1:0] care;
    logic [cafilt_pkg::BUS_W-1:0]  bfil;
    logic [cafilt_pkg::BUS_W-1:0]  bus;
    logic [cafilt_pkg::ID_W-1:0]   id;
    code = data[31:0];
    mask = data[63:32];
    bfil = data[79:64];
    id   = data[108:80];
    bus  = data[124:109];
    v    = '0;
    case (kind)
      cafilt_pkg::KIND_ADD: begin
        if (held < int'(MAX_ENTRIES)) begin
          code_tbl[held] = code;
          mask_tbl[held] = mask;
          bus_tbl[held]  = bfil;
          held++;
        end else begin
          v.dropped = 1'b1;
        end
      end
      cafilt_pkg::KIND_CLEAR: held = 0;
      cafilt_pkg::KIND_MATCH: begin
        for (int i = 0; i < held; i++) begin
          care = ~mask_tbl[i];
          if (!v.hit && ((cafilt_pkg::CODE_W'(id) & care) == (code_tbl[i] & care)) &&
              (bus_tbl[i] == bus || bus_tbl[i] == cafilt_pkg::BUS_ANY))
            v.hit = 1'b1;
        end
      end
      default: ;
    endcase
    v.count = (held > 255) ? 8'd255 : 8'(held);
    return v;
  endfunction

  task automatic report_fault(input string what);
    err_cnt++;
    $display("%0t ns: result %0d: %s", $time, res_cnt, what);
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      held = 0;
      verdict_q.delete();
    end else begin
      // results first: a result leaving at this edge belongs to an older word
      if (m_tvalid_i && m_tready_i) begin
        res_cnt++;
        if (verdict_q.size() == 0) begin
          report_fault($sformatf("result %h with no word outstanding", m_tdata_i));
        end else begin
          want = verdict_q.pop_front();
          if (want.hit) hit_cnt++;
          if (want.dropped) drop_cnt++;
          if (m_tdata_i[0] !== want.hit)
            report_fault($sformatf("matched %b, want %b", m_tdata_i[0], want.hit));
          if (m_tdata_i[1] !== want.dropped)
            report_fault($sformatf("add_dropped %b, want %b", m_tdata_i[1], want.dropped));
          if (m_tdata_i[9:2] !== want.count)
            report_fault($sformatf("filter_count %0d, want %0d", m_tdata_i[9:2],
                                   want.count));
          if (m_tdata_i[15:10] !== '0)
            report_fault($sformatf("pad bits %b, want zero", m_tdata_i[15:10]));
        end
      end
      if (s_tvalid_i && s_tready_i)
        verdict_q.push_back(table_step(s_tuser_i, s_tdata_i));
    end
    errors_o  <= err_cnt;
    pending_o <= verdict_q.size();
    results_o <= res_cnt;
    hits_o    <= hit_cnt;
    drops_o   <= drop_cnt;
  end

endmodule

FILE: test/tb_can_acceptance_filter_table_core.sv
// Testbench top for the CAN acceptance filter table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_can_acceptance_filter_table_core;

  localparam int unsigned TABLE_DEPTH  = cafilt_pkg::MAX_ENTRIES_DEF;
  localparam logic [cafilt_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;
  localparam int          TOTAL_WORDS  = 1550;
  localparam int          PHASE_WORDS  = 150;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          RESET_CYCLES = 12;

  // Every block input starts at a known value
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic [cafilt_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [cafilt_pkg::KIND_W-1:0]   s_axis_tuser  = '0;
  logic                            m_axis_tready = 1'b0;
  wire                             s_axis_tready;
  wire                             m_axis_tvalid;
  wire  [cafilt_pkg::M_DATA_W-1:0] m_axis_tdata;

  int errors;
  int pending;
  int results;
  int hits;
  int drops;

  // Stimulus bookkeeping: the filters the block should hold, for aiming probes
  cafilt_pkg::entry_t shadow [$];
  int          words_sent     = 0;
  int          adds_sent      = 0;
  int          adds_refused   = 0;
  int          clears_sent    = 0;
  int          matches_sent   = 0;
  int          unknowns_sent  = 0;
  int          seq_count      = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int          hold_left      = 0;
  int unsigned cycle_count    = 0;

  can_acceptance_filter_table_core #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  can_filter_table_checker #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .hits_o     (hits),
    .drops_o    (drops)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog: end the run if the block hangs or results never show up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: stall at the current rate, or hold off entirely for a long
  // stretch when asked so the block backs up into its input
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // tdata layout, low bit up: code, mask, bus filter, message id, message bus, pad
  function automatic logic [cafilt_pkg::S_DATA_W-1:0] pack_word(
      input logic [cafilt_pkg::CODE_W-1:0] code,
      input logic [cafilt_pkg::CODE_W-1:0] mask,
      input logic [cafilt_pkg::BUS_W-1:0]  bfil,
      input logic [cafilt_pkg::ID_W-1:0]   id,
      input logic [cafilt_pkg::BUS_W-1:0]  bus);
    return {3'b000, bus, id, bfil, mask, code};
  endfunction

  // Favor the corners: no mask, full mask, low-bit masks, sparse masks
  function automatic logic [cafilt_pkg::CODE_W-1:0] pick_mask();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF >> $urandom_range(31);
      default: return $urandom & $urandom;
    endcase
  endfunction

  // Mostly a handful of buses so probes collide, plus the wildcard and the full range
  function automatic logic [cafilt_pkg::BUS_W-1:0] pick_bus();
    case ($urandom_range(3))
      0:       return cafilt_pkg::BUS_ANY;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(3));
    endcase
  endfunction

  // Offer one word after a random idle gap and hold it until it is taken
  task automatic send_word(input logic [cafilt_pkg::KIND_W-1:0]   kind,
                           input logic [cafilt_pkg::S_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Add a filter; the match fields carry noise the block must ignore
  task automatic send_add(input logic [cafilt_pkg::CODE_W-1:0] code,
                          input logic [cafilt_pkg::CODE_W-1:0] mask,
                          input logic [cafilt_pkg::BUS_W-1:0]  bfil);
    cafilt_pkg::entry_t f;
    f.code = code;
    f.mask = mask;
    f.bus  = bfil;
    send_word(cafilt_pkg::KIND_ADD,
              pack_word(code, mask, bfil, 29'($urandom), 16'($urandom)));
    adds_sent++;
    if (shadow.size() < TABLE_DEPTH)
      shadow.push_back(f);
    else
      adds_refused++;
  endtask

  // Test a message; the filter fields carry noise
  task automatic send_match(input logic [cafilt_pkg::ID_W-1:0]  id,
                            input logic [cafilt_pkg::BUS_W-1:0] bus);
    send_word(cafilt_pkg::KIND_MATCH, pack_word($urandom, $urandom, 16'($urandom), id, bus));
    matches_sent++;
  endtask

  // Clear or unknown kind, with every field random
  task automatic send_other(input logic [cafilt_pkg::KIND_W-1:0] kind);
    send_word(kind, pack_word($urandom, $urandom, 16'($urandom), 29'($urandom),
                              16'($urandom)));
    if (kind == cafilt_pkg::KIND_CLEAR) begin
      shadow.delete();
      clears_sent++;
    end else begin
      unknowns_sent++;
    end
  endtask

  task automatic send_random_add();
    logic [cafilt_pkg::CODE_W-1:0] code;
    code = $urandom;
    // half the codes keep the bits above the identifier clear, so they can hit
    if ($urandom_range(1)) code[31:29] = 3'b000;
    send_add(code, pick_mask(), pick_bus());
  endtask

  // Aim most probes at a held filter, flip one bit for near misses, rest at random
  task automatic send_probe();
    cafilt_pkg::entry_t           f;
    logic [cafilt_pkg::ID_W-1:0]  id;
    logic [cafilt_pkg::BUS_W-1:0] bus;
    int                           sel;
    int                           bitpos;
    sel    = $urandom_range(99);
    id     = 29'($urandom);
    bus    = pick_bus();
    bitpos = $urandom_range(cafilt_pkg::ID_W - 1);
    if (shadow.size() != 0 && sel < 75) begin
      f  = shadow[$urandom_range(shadow.size() - 1)];
      id = (f.code[cafilt_pkg::ID_W-1:0] & ~f.mask[cafilt_pkg::ID_W-1:0]) |
           (id & f.mask[cafilt_pkg::ID_W-1:0]);
      if (f.bus != cafilt_pkg::BUS_ANY) bus = f.bus;
      if (sel >= 60) id[bitpos] = ~id[bitpos];
    end
    send_match(id, bus);
  endtask

  // One stretch of random stimulus: mostly build-then-probe, some raw noise
  task automatic run_sequence();
    logic [cafilt_pkg::KIND_W-1:0] kind;
    bit                            fill_up;
    int                            n_add;
    int                            n_probe;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) begin
        kind = cafilt_pkg::KIND_W'($urandom_range(3));
        case (kind)
          cafilt_pkg::KIND_ADD:   send_add($urandom, $urandom, 16'($urandom));
          cafilt_pkg::KIND_MATCH: send_match(29'($urandom), 16'($urandom));
          default:                send_other(kind);
        endcase
      end
    end else begin
      // now and then fill the table past capacity to provoke refused adds
      fill_up = (seq_count == 3) || ($urandom_range(999) < 15);
      if (fill_up || shadow.size() > 24 || $urandom_range(3) == 0)
        send_other(cafilt_pkg::KIND_CLEAR);
      n_add   = fill_up ? TABLE_DEPTH + $urandom_range(1, 3) : $urandom_range(1, 8);
      n_probe = fill_up ? 8 : $urandom_range(1, 6);
      repeat (n_add) send_random_add();
      repeat (n_probe) send_probe();
      if ($urandom_range(9) == 0) send_other(KIND_UNKNOWN);
    end
    seq_count++;
  endtask

  // Drop valid and wait until every outstanding word has produced its result
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, unknown kind, corner codes, masks and buses
    send_match(29'h1FFF_FFFF, 16'h0000);
    send_other(KIND_UNKNOWN);
    send_add(32'h0000_0000, 32'h0000_0000, 16'h0000);
    // unmasked ones above bit 28 can never be matched by a 29-bit id
    send_add(32'hFFFF_FFFF, 32'h0000_0000, cafilt_pkg::BUS_ANY);
    send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234);
    send_match(29'h0000_0000, 16'h0000);
    // a message on bus 0xFFFF is no wildcard: only filters may be
    send_match(29'h1FFF_FFFF, cafilt_pkg::BUS_ANY);
    send_match(29'h1FFF_FFFF, 16'h1234);
    // high code bits set but masked off
    send_add(32'hE000_0ABC, 32'hE000_0000, cafilt_pkg::BUS_ANY);
    send_match(29'h0000_0ABC, 16'h0007);
    send_match(29'h0000_0ABD, 16'h0007);
    send_other(cafilt_pkg::KIND_CLEAR);
    send_match(29'h0000_0000, 16'h0000);
    send_add(32'h1FFF_FFFF, 32'h0000_0000, 16'hFFFE);
    send_match(29'h1FFF_FFFF, cafilt_pkg::BUS_ANY);
    send_match(29'h1FFF_FFFF, 16'hFFFE);
    send_other(KIND_UNKNOWN);
    send_other(cafilt_pkg::KIND_CLEAR);

    // Random: rotate idle phases, hold off the output once, pause once
    while (words_sent < TOTAL_WORDS) begin
      case ((words_sent / PHASE_WORDS) % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      if (seq_count == 60) hold_request = 1'b1;
      if (seq_count == 110) wait_all_results();
      run_sequence();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Drove %0d words: %0d adds (%0d on a full table), %0d clears, %0d matches,",
             words_sent, adds_sent, adds_refused, clears_sent, matches_sent);
    $display("  %0d unknown; checked %0d results (%0d hits, %0d refused adds) in all phases",
             unknowns_sent, results, hits, drops);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
